[sv/pesm_pkg.sv]
// Shared types, constants and sequencer states for the product-except-self block.
`default_nettype none

package pesm_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_W          = 32;
    localparam int MOD_W            = 16;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 16'd12345;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last_in;
    } request_t;

    typedef struct packed {
        logic [MOD_W-1:0] product;
        logic             last_out;
        logic             overflow;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_BW_READ,
        S_BW_MUL,
        S_BW_MOD,
        S_FW_READ,
        S_FW_MUL1,
        S_FW_MOD1,
        S_FW_MUL2,
        S_FW_MOD2
    } state_t;

endpackage

`default_nettype wire

[sv/pesm_modu.sv]
// Radix-2 restoring remainder unit: 32-bit dividend modulo 16-bit divisor.
`default_nettype none

module pesm_modu
    import pesm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [MOD_W-1:0]   divisor,
    output logic                    done,
    output logic [MOD_W-1:0]        remainder
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               run_reg,  run_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [VALUE_W-1:0] dvd_reg,  dvd_next;
    logic [MOD_W-1:0]   div_reg,  div_next;
    logic [MOD_W-1:0]   rem_reg,  rem_next;

    logic [MOD_W:0]     trial;
    logic [MOD_W-1:0]   trial_sub;
    logic               fits;

    // one quotient bit per cycle; partial remainder always stays below divisor
    assign trial     = {rem_reg, dvd_reg[VALUE_W-1]};
    assign trial_sub = trial[MOD_W-1:0] - div_reg;
    assign fits      = (trial >= {1'b0, div_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            div_next = divisor;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = fits ? trial_sub : trial[MOD_W-1:0];
            dvd_next = {dvd_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[sv/product_except_self_mod_core.sv]
// Top level: modular product of every other element of a flat run.
// Usage:
//   Request channel: a request (value, last_in) is taken on a rising edge with
//   start high and busy low. Each value is reduced modulo the modulus and kept
//   in the residue memory. A request with last_in set closes the run.
//   Result channel: result_valid strobes for one cycle per result; results come
//   in arrival order, last_out on the final one, overflow on all of them when
//   the run overran MAX_ELEMENTS (extra values are dropped, a dropped last_in
//   still closes the run). The receiver cannot stall; none is needed.
//   Config: cfg_we writes cfg_wdata into the modulus (0 and 1 act as 1).
// Sequence:
//   load: each stored request runs one 32-step remainder.
//   after the closing request: a backward suffix pass, one remainder per
//   element, then a forward pass, two remainders and one result per element.
//   Every step runs through the single shared radix-2 remainder unit; a
//   dropped non-final request leaves the sequencer idle.
// Reset: asynchronous, clears the run (count, overflow, sequencer) and loads
//   the modulus with 12345. Memories hold garbage until written; only entries
//   of the current run are read.
`default_nettype none

module product_except_self_mod_core
    import pesm_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire request_t         request,
    output logic                  result_valid,
    output result_t               result,
    input  wire logic             cfg_we,
    input  wire logic [MOD_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    // sequencer and run state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg,   ovf_next;
    logic              last_reg,  last_next;
    logic [ADDR_W-1:0] k_reg,     k_next;
    logic [MOD_W-1:0]  acc_reg,   acc_next;     // suffix acc, then prefix acc
    logic [MOD_W-1:0]  modulus_reg;
    result_t           result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    // memories: residues in arrival order, exclusive suffix products
    logic [MOD_W-1:0]  res_mem [MAX_ELEMENTS];
    logic [MOD_W-1:0]  suf_mem [MAX_ELEMENTS];
    logic [MOD_W-1:0]  res_rd_reg;
    logic [MOD_W-1:0]  suf_rd_reg;

    // FSM outputs
    logic               mod_start;
    logic [VALUE_W-1:0] mod_dividend;
    logic               res_we;
    logic               res_re;
    logic               suf_we;
    logic               suf_re;

    logic               mod_done;
    logic [MOD_W-1:0]   mod_rem;
    logic [MOD_W-1:0]   m_eff;
    logic [MOD_W-1:0]   one_m;
    logic               accept;
    logic               has_room;
    logic [ADDR_W-1:0]  last_idx;
    logic [ADDR_W-1:0]  cnt_idx;

    assign m_eff    = (modulus_reg < MOD_W'(2)) ? MOD_W'(1) : modulus_reg;
    assign one_m    = (modulus_reg < MOD_W'(2)) ? '0 : MOD_W'(1);   // 1 mod m
    assign accept   = start && (state_reg == S_IDLE);
    assign has_room = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign last_idx = ADDR_W'(count_reg - 1'b1);
    assign cnt_idx  = count_reg[ADDR_W-1:0];

    pesm_modu u_modu (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (m_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (has_room)
                        state_next = S_LOAD;
                    else if (request.last_in)
                        state_next = S_BW_READ;
                end
            end
            S_LOAD:
            begin
                if (mod_done)
                    state_next = last_reg ? S_BW_READ : S_IDLE;
            end
            S_BW_READ: state_next = S_BW_MUL;
            S_BW_MUL:  state_next = S_BW_MOD;
            S_BW_MOD:
            begin
                if (mod_done)
                    state_next = (k_reg == '0) ? S_FW_READ : S_BW_READ;
            end
            S_FW_READ: state_next = S_FW_MUL1;
            S_FW_MUL1: state_next = S_FW_MOD1;
            S_FW_MOD1:
            begin
                if (mod_done)
                    state_next = S_FW_MUL2;
            end
            S_FW_MUL2: state_next = S_FW_MOD2;
            S_FW_MOD2:
            begin
                if (mod_done)
                    state_next = (k_reg == last_idx) ? S_IDLE : S_FW_READ;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // FSM outputs: remainder unit launches and memory strobes
    always_comb
    begin
        mod_start    = 1'b0;
        mod_dividend = '0;
        res_we       = 1'b0;
        res_re       = 1'b0;
        suf_we       = 1'b0;
        suf_re       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && has_room)
                begin
                    mod_start    = 1'b1;
                    mod_dividend = request.value;
                end
            end
            S_LOAD:    res_we = mod_done;
            S_BW_READ:
            begin
                suf_we = 1'b1;
                res_re = 1'b1;
            end
            S_BW_MUL:
            begin
                mod_start    = 1'b1;
                mod_dividend = VALUE_W'(acc_reg) * VALUE_W'(res_rd_reg);
            end
            S_FW_READ:
            begin
                res_re = 1'b1;
                suf_re = 1'b1;
            end
            S_FW_MUL1:
            begin
                mod_start    = 1'b1;
                mod_dividend = VALUE_W'(acc_reg) * VALUE_W'(suf_rd_reg);
            end
            S_FW_MUL2:
            begin
                mod_start    = 1'b1;
                mod_dividend = VALUE_W'(acc_reg) * VALUE_W'(res_rd_reg);
            end
            default:
            begin
                mod_start = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        last_next         = last_reg;
        k_next            = k_reg;
        acc_next          = acc_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = request.last_in;
                    if (!has_room)
                    begin
                        ovf_next = 1'b1;
                        k_next   = last_idx;
                        acc_next = one_m;
                    end
                end
            end
            S_LOAD:
            begin
                if (mod_done)
                begin
                    count_next = count_reg + 1'b1;
                    k_next     = cnt_idx;       // new entry is the last one
                    acc_next   = one_m;
                end
            end
            S_BW_MOD:
            begin
                if (mod_done)
                begin
                    if (k_reg == '0)
                        acc_next = one_m;       // prefix starts fresh
                    else
                    begin
                        acc_next = mod_rem;
                        k_next   = k_reg - 1'b1;
                    end
                end
            end
            S_FW_MOD1:
            begin
                if (mod_done)
                begin
                    result_next.product  = mod_rem;
                    result_next.last_out = (k_reg == last_idx);
                    result_next.overflow = ovf_reg;
                    result_valid_next    = 1'b1;
                end
            end
            S_FW_MOD2:
            begin
                if (mod_done)
                begin
                    acc_next = mod_rem;
                    if (k_reg == last_idx)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            modulus_reg      <= MODULUS_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                modulus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    // Memory ports. Writes and reads of one entry never overlap: the load
    // phase only writes, and the passes read an entry only after its write,
    // so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[cnt_idx] <= mod_rem;
        if (res_re)
            res_rd_reg <= res_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (suf_we)
            suf_mem[k_reg] <= acc_reg;
        if (suf_re)
            suf_rd_reg <= suf_mem[k_reg];
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a pass");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_FW_MOD1 && mod_done))
        else $error("result strobe without a finished prefix-suffix product");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.overflow == ovf_reg))
        else $error("overflow flag differs from run state");
`endif

endmodule

`default_nettype wire

[tb/pesm_checker.sv]
// Checker: predicts the modular product-except-self results and compares them with the block.
module pesm_checker
    import pesm_pkg::*;
#(
    parameter int CAPACITY = MAX_ELEMENTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  request_t         request,
    input  logic             result_valid,
    input  result_t          result,
    input  logic             cfg_we,
    input  logic [MOD_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               pending_results,
    output int               results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [MOD_W-1:0] modulus_q;
    logic [MOD_W-1:0] residues [CAPACITY];
    int               stored;
    bit               dropped;
    result_t          product_queue [$];

    // operands stay below 2^16, so the product fits 32 bits
    function automatic int unsigned mod_mul(int unsigned a, int unsigned b, int unsigned m);
        return (a * b) % m;
    endfunction

    function automatic int unsigned active_modulus();
        return (modulus_q < 2) ? 1 : int'(modulus_q);
    endfunction

    task automatic predict_products(input request_t rq);
        int unsigned m;
        int unsigned acc;
        int unsigned pre;
        int unsigned suffix [CAPACITY];
        result_t     want;
        m = active_modulus();
        if (stored < CAPACITY) begin
            residues[stored] = MOD_W'(rq.value % m);
            stored++;
        end
        else begin
            dropped = 1'b1;
        end
        if (rq.last_in) begin
            // exclusive suffix products, then prefix times suffix in arrival order
            acc = 1 % m;
            for (int k = stored - 1; k >= 0; k--) begin
                suffix[k] = acc;
                acc = mod_mul(acc, residues[k], m);
            end
            pre = 1 % m;
            for (int k = 0; k < stored; k++) begin
                want.product  = MOD_W'(mod_mul(pre, suffix[k], m));
                want.last_out = (k == stored - 1);
                want.overflow = dropped;
                product_queue.push_back(want);
                pre = mod_mul(pre, residues[k], m);
            end
            stored  = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic check_product(input result_t got);
        result_t want;
        results_seen++;
        if (product_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] unexpected result: product=%0d last=%0b ovf=%0b",
                         $realtime, got.product, got.last_out, got.overflow);
        end
        else begin
            want = product_queue.pop_front();
            if (got.product !== want.product || got.last_out !== want.last_out ||
                got.overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] expected %0d/%0b/%0b, got %0d/%0b/%0b (product/last/ovf)",
                             $realtime, want.product, want.last_out, want.overflow,
                             got.product, got.last_out, got.overflow);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            modulus_q       = MODULUS_RESET;
            stored          = 0;
            dropped         = 1'b0;
            mismatches      = 0;
            results_seen    = 0;
            pending_results = 0;
            product_queue.delete();
        end
        else begin
            if (result_valid)
                check_product(result);
            if (start && !busy)
                predict_products(request);
            if (cfg_we)
                modulus_q = cfg_wdata;
            pending_results = product_queue.size();
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench top: stimulus, modulus writes, watchdog and verdict for the product-except-self block.
module tb_top
    import pesm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 230;
    localparam int SETTLE_CYCLES   = 80;     // covers one pending load with margin
    localparam int DRAIN_CYCLES    = 150;
    // Slowest quiet stretch is the suffix pass of a full run;
    // take it several times over.
    localparam int WATCHDOG_LIMIT  = 20000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    request_t         request;
    logic             result_valid;
    result_t          result;
    logic             cfg_we;
    logic [MOD_W-1:0] cfg_wdata;

    int mismatches;
    int pending_results;
    int results_seen;

    int          elements_sent;
    int          runs_closed;
    int          overflow_runs;
    int          modulus_writes;
    int          burst_left;
    int          quiet_cycles;
    int unsigned cur_modulus;

    product_except_self_mod_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    pesm_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .result_valid    (result_valid),
        .result          (result),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    always #5 clk = ~clk;

    // Watchdog: any request or result taken restarts the count.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d cycles with no traffic", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Element mix: zero, all ones, exact multiples of the modulus (zero residue),
    // small values and full-width random.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned m;
        m = (cur_modulus < 2) ? 1 : cur_modulus;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'(m * $urandom_range(0, 65535));
            3:       return VALUE_W'($urandom_range(0, 255));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_modulus();
        case ($urandom_range(0, 6))
            0:       return 2;
            1:       return 65535;
            2:       return 12345;
            3:       return $urandom_range(2, 255);
            default: return $urandom_range(3, 65534);
        endcase
    endfunction

    // One request. The sender works in bursts; between bursts start drops for a
    // random gap so idle time lands on load, suffix and emit phases alike.
    // Inputs only move on the falling edge; acceptance is seen on the rising edge.
    task automatic send_element(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 4))
                0:       gap = 0;
                1:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 8);
            endcase
            burst_left = $urandom_range(1, 12);
        end
        else begin
            gap = 0;
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= '{value: value, last_in: last};
        do @(posedge clk); while (busy);
        elements_sent++;
        if (last)
            runs_closed++;
    endtask

    // Drop start, let all predicted results come out, then give a pending load
    // time to finish before touching the modulus.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic set_modulus(input int unsigned m);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= MOD_W'(m);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        cur_modulus = m;
        modulus_writes++;
    endtask

    task automatic run_matrix(input int len);
        for (int i = 0; i < len; i++)
            send_element(pick_value(), i == len - 1);
        if (len > MAX_ELEMENTS_DEF)
            overflow_runs++;
    endtask

    initial
    begin
        int len;
        int run_idx;
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        elements_sent  = 0;
        runs_closed    = 0;
        overflow_runs  = 0;
        modulus_writes = 0;
        burst_left     = 0;
        quiet_cycles   = 0;
        cur_modulus    = 12345;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // single-element run under the reset modulus: product is 1
        send_element(32'hFFFF_FFFF, 1'b1);
        // all-ones, zero element, residue one
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'd7, 1'b0);
        send_element(32'd12346, 1'b1);
        // modulus changed between elements of one run: old residues keep their reduction
        send_element(32'h8000_0001, 1'b0);
        send_element(32'h0001_869F, 1'b0);
        set_modulus(65535);
        send_element(32'hDEAD_BEEF, 1'b1);
        // modulus zero and one both act as one: every product is 0
        set_modulus(0);
        send_element(32'd40000, 1'b0);
        send_element(32'd3, 1'b1);
        set_modulus(1);
        send_element(32'd5, 1'b1);
        // smallest real modulus
        set_modulus(2);
        send_element(32'd3, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'd1, 1'b1);

        // --- random runs ---
        // First run overruns capacity so the dropped closing element is always hit;
        // later runs are mostly short with an occasional near-capacity one.
        run_idx = 0;
        while (elements_sent < TARGET_REQUESTS) begin
            if (run_idx % 4 == 0)
                set_modulus(pick_modulus());
            if (run_idx == 0)
                len = MAX_ELEMENTS_DEF + 1;
            else begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(MAX_ELEMENTS_DEF - 1, MAX_ELEMENTS_DEF + 3);
                    1, 2:    len = $urandom_range(9, 24);
                    default: len = $urandom_range(1, 8);
                endcase
            end
            run_matrix(len);
            run_idx++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests in %0d runs (%0d over capacity) across %0d modulus writes.",
                 elements_sent, runs_closed, overflow_runs, modulus_writes);
        $display("Checked %0d results, %0d mismatches, %0d still outstanding.",
                 results_seen, mismatches, pending_results);
        if (mismatches == 0 && pending_results == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
